FILE: rtl/haver_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// haver_pkg
// Shared types, constants and the arctangent table of the haversine datapath.
// ----------------------------------------------------------------------------
package haver_pkg;

  // Binary angle, 2^32 units per turn.
  typedef logic [31:0] bangle_t;
  // Sine or cosine in Q30.
  typedef logic signed [31:0] trig_t;

  localparam int SQRT_STEPS = 31;

  // Reciprocal of 45 for exact floor division of values below 2^30.
  localparam logic [30:0] DIV45_MUL   = 31'd1527099484;
  localparam int          DIV45_SHIFT = 36;

  localparam logic [31:0] GAIN_Q30   = 32'd652032875;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [30:0] DIST_SCALE = 31'd1280965555;
  localparam logic [29:0] SENTINEL_M = 30'd999999000;

  // Arctangent of 2^-i in binary angle units.
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:  val = 32'h20000000;
      5'd1:  val = 32'h12E4051E;
      5'd2:  val = 32'h09FB385B;
      5'd3:  val = 32'h051111D4;
      5'd4:  val = 32'h028B0D43;
      5'd5:  val = 32'h0145D7E1;
      5'd6:  val = 32'h00A2F61E;
      5'd7:  val = 32'h00517C55;
      5'd8:  val = 32'h0028BE53;
      5'd9:  val = 32'h00145F2F;
      5'd10: val = 32'h000A2F98;
      5'd11: val = 32'h000517CC;
      5'd12: val = 32'h00028BE6;
      5'd13: val = 32'h000145F3;
      5'd14: val = 32'h0000A2FA;
      5'd15: val = 32'h0000517D;
      5'd16: val = 32'h000028BE;
      5'd17: val = 32'h0000145F;
      5'd18: val = 32'h00000A30;
      5'd19: val = 32'h00000518;
      5'd20: val = 32'h0000028C;
      5'd21: val = 32'h00000146;
      5'd22: val = 32'h000000A3;
      5'd23: val = 32'h00000051;
      5'd24: val = 32'h00000029;
      5'd25: val = 32'h00000014;
      5'd26: val = 32'h0000000A;
      5'd27: val = 32'h00000005;
      5'd28: val = 32'h00000003;
      5'd29: val = 32'h00000001;
      5'd30: val = 32'h00000001;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/haver_bang.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// haver_bang
// Converts signed fixed-point degrees to a binary angle, dividing by
// 45 * 2^DIV_SHIFT with rounding half away from zero. Four register stages.
// ----------------------------------------------------------------------------
module haver_bang #(
  parameter int DEG_W     = 29,
  parameter int DIV_SHIFT = 4,
  parameter int FRAC_BITS = 20
) (
  input  wire logic                    clk,
  input  wire logic signed [DEG_W-1:0] deg,
  output haver_pkg::bangle_t           ang
);

  localparam int SH = 32 - FRAC_BITS;
  localparam int QW = DEG_W - 5;
  localparam int VW = SH + 7;

  // Stage 1: magnitude and its product with the reciprocal of 45.
  logic [DEG_W-1:0] mag_c;
  logic [DEG_W-1:0] mag1;
  logic [DEG_W+30:0] prod1;
  logic sign1;

  assign mag_c = deg[DEG_W-1] ? DEG_W'(-deg) : DEG_W'(deg);

  always_ff @(posedge clk) begin
    sign1 <= deg[DEG_W-1];
    mag1  <= mag_c;
    prod1 <= (DEG_W+31)'(mag_c) * (DEG_W+31)'(haver_pkg::DIV45_MUL);
  end

  // Stage 2: quotient and remainder of the magnitude by 45.
  logic [QW-1:0] qa_c;
  logic [DEG_W-1:0] qm_c;
  logic [QW-1:0] qa2;
  logic [5:0] ra2;
  logic sign2;

  assign qa_c = QW'(prod1 >> haver_pkg::DIV45_SHIFT);
  assign qm_c = DEG_W'(qa_c) * DEG_W'(6'd45);

  always_ff @(posedge clk) begin
    sign2 <= sign1;
    qa2   <= qa_c;
    ra2   <= 6'(mag1 - qm_c);
  end

  // Stage 3: the remainder scaled to angle units, rounded, divided again.
  logic [VW-1:0] v_c;
  logic [VW-1:0] u_c;
  logic [63:0] prod3;
  logic [QW-1:0] qa3;
  logic sign3;

  assign v_c = (VW'(ra2) << SH) + (VW'(6'd45) << (DIV_SHIFT - 1));
  assign u_c = v_c >> DIV_SHIFT;

  always_ff @(posedge clk) begin
    sign3 <= sign2;
    qa3   <= qa2;
    prod3 <= 64'(u_c) * 64'(haver_pkg::DIV45_MUL);
  end

  // Stage 4: full quotient, sign restored, wrapped to one turn.
  logic [63:0] q_c;

  assign q_c = (64'(qa3) << (SH - DIV_SHIFT)) + (prod3 >> haver_pkg::DIV45_SHIFT);

  always_ff @(posedge clk) begin
    ang <= sign3 ? 32'(-q_c) : 32'(q_c);
  end

endmodule
`default_nettype wire

FILE: rtl/haver_rot.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// haver_rot
// Pipelined rotation CORDIC: sine and cosine of a binary angle in Q30.
// One stage folds the angle into a quadrant, one stage per iteration, one
// stage maps the quadrant back.
// ----------------------------------------------------------------------------
module haver_rot #(
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic               clk,
  input  wire haver_pkg::bangle_t ang,
  output haver_pkg::trig_t        sin_out,
  output haver_pkg::trig_t        cos_out
);

  localparam int CW = 34;
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  logic signed [CW-1:0] x_q [0:CORDIC_STEPS];
  logic signed [CW-1:0] y_q [0:CORDIC_STEPS];
  logic signed [CW-1:0] z_q [0:CORDIC_STEPS];
  logic [1:0] quad_q [0:CORDIC_STEPS];

  // Quadrant fold: the residual angle lies within plus or minus 45 degrees.
  logic [31:0] sum_c;
  logic [1:0] quad_c;
  logic [31:0] d_c;

  assign sum_c  = ang + 32'h2000_0000;
  assign quad_c = sum_c[31:30];
  assign d_c    = ang - {quad_c, 30'd0};

  always_ff @(posedge clk) begin
    quad_q[0] <= quad_c;
    z_q[0]    <= CW'($signed(d_c));
    x_q[0]    <= CW'($signed(haver_pkg::GAIN_Q30));
    y_q[0]    <= '0;
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [CW-1:0] ATAN = CW'(haver_pkg::atan_entry(5'(i)));

    always_ff @(posedge clk) begin
      quad_q[i+1] <= quad_q[i];
      if (!z_q[i][CW-1]) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - ATAN;
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + ATAN;
      end
    end
  end

  // Quadrant map back to the full circle.
  haver_pkg::trig_t xt;
  haver_pkg::trig_t yt;

  assign xt = $signed(x_q[CORDIC_STEPS][31:0]);
  assign yt = $signed(y_q[CORDIC_STEPS][31:0]);

  always_ff @(posedge clk) begin
    case (quad_q[CORDIC_STEPS])
      QUAD_0: begin
        cos_out <= xt;
        sin_out <= yt;
      end
      QUAD_1: begin
        cos_out <= -yt;
        sin_out <= xt;
      end
      QUAD_2: begin
        cos_out <= -xt;
        sin_out <= -yt;
      end
      default: begin
        cos_out <= yt;
        sin_out <= -xt;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/haver_term.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// haver_term
// Forms the haversine term a = sin^2(dlat/2) + cos(lat1) cos(lat2)
// sin^2(dlon/2), saturates it to [0, 1] and produces the two Q60 radicands
// (1 - a) and a. Three register stages.
// ----------------------------------------------------------------------------
module haver_term (
  input  wire logic             clk,
  input  wire haver_pkg::trig_t s1,
  input  wire haver_pkg::trig_t s2,
  input  wire haver_pkg::trig_t c3,
  input  wire haver_pkg::trig_t c4,
  output logic [60:0]           cos_side,
  output logic [60:0]           sin_side
);

  // Stage 1: three products in Q30.
  logic signed [63:0] pcc_c;
  logic signed [63:0] p22_c;
  logic signed [63:0] p11_c;
  logic signed [33:0] cc1;
  logic signed [33:0] s2sq1;
  logic signed [33:0] s1sq1;

  assign pcc_c = c3 * c4;
  assign p22_c = s2 * s2;
  assign p11_c = s1 * s1;

  always_ff @(posedge clk) begin
    cc1   <= 34'(pcc_c >>> 30);
    s2sq1 <= 34'(p22_c >>> 30);
    s1sq1 <= 34'(p11_c >>> 30);
  end

  // Stage 2: the longitude term.
  logic signed [67:0] pt_c;
  logic signed [33:0] t2;
  logic signed [33:0] s1sq2;

  assign pt_c = cc1 * s2sq1;

  always_ff @(posedge clk) begin
    t2    <= 34'(pt_c >>> 30);
    s1sq2 <= s1sq1;
  end

  // Stage 3: sum, saturate and scale to Q60.
  logic signed [34:0] a_c;
  logic [30:0] a_sat;

  assign a_c = 35'(s1sq2) + 35'(t2);

  always_comb begin
    if (a_c[34]) begin
      a_sat = '0;
    end else if (a_c > 35'(haver_pkg::ONE_Q30)) begin
      a_sat = haver_pkg::ONE_Q30;
    end else begin
      a_sat = 31'(a_c);
    end
  end

  always_ff @(posedge clk) begin
    sin_side <= 61'(a_sat) << 30;
    cos_side <= 61'(haver_pkg::ONE_Q30 - a_sat) << 30;
  end

endmodule
`default_nettype wire

FILE: rtl/haver_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// haver_isqrt
// Pipelined floor square root of a 61-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module haver_isqrt (
  input  wire logic        clk,
  input  wire logic [60:0] val,
  output logic [30:0]      root
);

  localparam int N = haver_pkg::SQRT_STEPS;

  logic [61:0] v_q [1:N];
  logic [61:0] r_q [1:N];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [61:0] BIT = 62'(1) << (2 * (N - 1 - k));
    logic [61:0] v_in;
    logic [61:0] r_in;
    logic [61:0] trial;

    if (k == 0) begin : g_first
      assign v_in = {1'b0, val};
      assign r_in = '0;
    end else begin : g_rest
      assign v_in = v_q[k];
      assign r_in = r_q[k];
    end

    assign trial = r_in + BIT;

    // Keep the bit where the trial square still fits.
    always_ff @(posedge clk) begin
      if (v_in >= trial) begin
        v_q[k+1] <= v_in - trial;
        r_q[k+1] <= (r_in >> 1) + BIT;
      end else begin
        v_q[k+1] <= v_in;
        r_q[k+1] <= r_in >> 1;
      end
    end
  end

  assign root = r_q[N][30:0];

endmodule
`default_nettype wire

FILE: rtl/haver_vec.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// haver_vec
// Pipelined vectoring CORDIC: angle of (x, y) in binary angle units,
// saturated to [0, 90 degrees]. One stage per iteration plus a saturation
// stage.
// ----------------------------------------------------------------------------
module haver_vec #(
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic        clk,
  input  wire logic [30:0] x_in,
  input  wire logic [30:0] y_in,
  output logic [30:0]      z_out
);

  localparam int CW = 34;

  logic signed [CW-1:0] x_q [1:CORDIC_STEPS];
  logic signed [CW-1:0] y_q [1:CORDIC_STEPS];
  logic signed [CW-1:0] z_q [1:CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [CW-1:0] ATAN = CW'(haver_pkg::atan_entry(5'(i)));
    logic signed [CW-1:0] xi;
    logic signed [CW-1:0] yi;
    logic signed [CW-1:0] zi;

    if (i == 0) begin : g_first
      assign xi = $signed({3'b000, x_in});
      assign yi = $signed({3'b000, y_in});
      assign zi = '0;
    end else begin : g_rest
      assign xi = x_q[i];
      assign yi = y_q[i];
      assign zi = z_q[i];
    end

    // Rotate toward the x axis, accumulating the angle.
    always_ff @(posedge clk) begin
      if (!yi[CW-1]) begin
        x_q[i+1] <= xi + (yi >>> i);
        y_q[i+1] <= yi - (xi >>> i);
        z_q[i+1] <= zi + ATAN;
      end else begin
        x_q[i+1] <= xi - (yi >>> i);
        y_q[i+1] <= yi + (xi >>> i);
        z_q[i+1] <= zi - ATAN;
      end
    end
  end

  // Saturate the half central angle.
  logic signed [CW-1:0] zf;

  assign zf = z_q[CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (zf[CW-1]) begin
      z_out <= '0;
    end else if (zf > CW'(haver_pkg::ONE_Q30)) begin
      z_out <= haver_pkg::ONE_Q30;
    end else begin
      z_out <= 31'(zf);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/haversine_distance.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// haversine_distance
// Great-circle distance in metres from a station to a configured target.
// ----------------------------------------------------------------------------
// Usage:
//   Write target_lat at byte address 0 and target_lon at address 4 over the
//   APB port while no beat is in flight. Present a station position on
//   station_lat / station_lon with start high; busy is always low, so a beat
//   is taken in every cycle that start is high.
//   Each beat produces one result beat: done is high for one cycle with
//   distance_m and coords_invalid. Beats are taken and answered at one per
//   cycle; the pipeline depth is set mostly by the two CORDIC chains (one
//   stage per iteration) and the 31-stage square root. If any coordinate is
//   exactly zero the result is 999999000 with coords_invalid set.
//   Reset clears the configuration registers and the valid line, dropping beats in flight.
//   The receiver cannot stall; results are shown once and never held.
// ----------------------------------------------------------------------------
module haversine_distance #(
  parameter int FRAC_BITS    = 20,
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [27:0] station_lat,
  input  wire logic signed [28:0] station_lon,
  output logic                    done,
  output logic [29:0]             distance_m,
  output logic                    coords_invalid,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam logic REG_TARGET_LAT = 1'b0;
  localparam logic REG_TARGET_LON = 1'b1;

  localparam int BANG_LAT = 4;
  localparam int ROT_LAT  = CORDIC_STEPS + 2;
  localparam int TERM_LAT = 3;
  localparam int SQRT_LAT = haver_pkg::SQRT_STEPS;
  localparam int VEC_LAT  = CORDIC_STEPS + 1;
  localparam int PIPE_LAT = 1 + BANG_LAT + ROT_LAT + TERM_LAT + SQRT_LAT + VEC_LAT + 2;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Configuration registers.
  logic signed [27:0] target_lat;
  logic signed [28:0] target_lon;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_lat <= '0;
      target_lon <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_TARGET_LAT: target_lat <= pwdata[27:0];
        REG_TARGET_LON: target_lon <= pwdata[28:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TARGET_LAT: prdata = {4'd0, target_lat};
      REG_TARGET_LON: prdata = {3'd0, target_lon};
      default:        prdata = '0;
    endcase
  end

  // Valid and invalid-flag line that travels alongside the datapath.
  logic accept;
  logic [PIPE_LAT-1:0] vld_line;
  logic [PIPE_LAT-1:0] inv_line;
  logic zero_c;

  assign accept = start && !busy;
  assign zero_c = (station_lat == '0) || (station_lon == '0) ||
                  (target_lat == '0) || (target_lon == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_line <= '0;
    end else begin
      vld_line <= {vld_line[PIPE_LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    inv_line <= {inv_line[PIPE_LAT-2:0], zero_c};
  end

  // Input stage: coordinate differences.
  logic signed [28:0] dlat;
  logic signed [29:0] dlon;
  logic signed [27:0] slat;
  logic signed [27:0] tlat;

  always_ff @(posedge clk) begin
    dlat <= 29'(target_lat) - 29'(station_lat);
    dlon <= 30'(target_lon) - 30'(station_lon);
    slat <= station_lat;
    tlat <= target_lat;
  end

  // Degrees to binary angles: half angles for the differences.
  haver_pkg::bangle_t ang1;
  haver_pkg::bangle_t ang2;
  haver_pkg::bangle_t ang3;
  haver_pkg::bangle_t ang4;

  haver_bang #(.DEG_W(29), .DIV_SHIFT(4), .FRAC_BITS(FRAC_BITS)) u_bang1 (
    .clk(clk), .deg(dlat), .ang(ang1)
  );
  haver_bang #(.DEG_W(30), .DIV_SHIFT(4), .FRAC_BITS(FRAC_BITS)) u_bang2 (
    .clk(clk), .deg(dlon), .ang(ang2)
  );
  haver_bang #(.DEG_W(28), .DIV_SHIFT(3), .FRAC_BITS(FRAC_BITS)) u_bang3 (
    .clk(clk), .deg(slat), .ang(ang3)
  );
  haver_bang #(.DEG_W(28), .DIV_SHIFT(3), .FRAC_BITS(FRAC_BITS)) u_bang4 (
    .clk(clk), .deg(tlat), .ang(ang4)
  );

  // Sines and cosines.
  haver_pkg::trig_t s1;
  haver_pkg::trig_t s2;
  haver_pkg::trig_t c3;
  haver_pkg::trig_t c4;

  haver_rot #(.CORDIC_STEPS(CORDIC_STEPS)) u_rot1 (
    .clk(clk), .ang(ang1), .sin_out(s1), .cos_out()
  );
  haver_rot #(.CORDIC_STEPS(CORDIC_STEPS)) u_rot2 (
    .clk(clk), .ang(ang2), .sin_out(s2), .cos_out()
  );
  haver_rot #(.CORDIC_STEPS(CORDIC_STEPS)) u_rot3 (
    .clk(clk), .ang(ang3), .sin_out(), .cos_out(c3)
  );
  haver_rot #(.CORDIC_STEPS(CORDIC_STEPS)) u_rot4 (
    .clk(clk), .ang(ang4), .sin_out(), .cos_out(c4)
  );

  // Haversine term and radicands.
  logic [60:0] cos_side;
  logic [60:0] sin_side;

  haver_term u_term (
    .clk(clk), .s1(s1), .s2(s2), .c3(c3), .c4(c4),
    .cos_side(cos_side), .sin_side(sin_side)
  );

  // Square roots.
  logic [30:0] root_cos;
  logic [30:0] root_sin;

  haver_isqrt u_sqrt_cos (.clk(clk), .val(cos_side), .root(root_cos));
  haver_isqrt u_sqrt_sin (.clk(clk), .val(sin_side), .root(root_sin));

  // Half central angle.
  logic [30:0] half_ang;

  haver_vec #(.CORDIC_STEPS(CORDIC_STEPS)) u_vec (
    .clk(clk), .x_in(root_cos), .y_in(root_sin), .z_out(half_ang)
  );

  // Scale to metres, round half up and select the sentinel.
  logic [61:0] dist_prod;
  logic [62:0] dist_rnd;

  always_ff @(posedge clk) begin
    dist_prod <= 62'(half_ang) * 62'(haver_pkg::DIST_SCALE);
  end

  assign dist_rnd = 63'(dist_prod) + (63'(1) << 35);

  always_ff @(posedge clk) begin
    distance_m     <= inv_line[PIPE_LAT-2] ? haver_pkg::SENTINEL_M : 30'(dist_rnd >> 36);
    coords_invalid <= inv_line[PIPE_LAT-2];
  end

  assign done = vld_line[PIPE_LAT-1];

endmodule
`default_nettype wire

FILE: rtl/haver_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// haver_checker
// Port-level checks of the distance block: latency, sentinel and range.
// ----------------------------------------------------------------------------
module haver_checker #(
  parameter int CORDIC_STEPS = 24
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic signed [27:0] station_lat,
  input wire logic               done,
  input wire logic [29:0]        distance_m,
  input wire logic               coords_invalid
);

  localparam int LAT = 2 * CORDIC_STEPS + 44;
  localparam logic [29:0] SENTINEL = 30'd999999000;
  localparam logic [29:0] MAX_DIST = 30'd20015087;

  // Every accepted beat is answered after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("result beat missing after accepted input");

  // No result beat without an input beat the latency earlier.
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result beat without input beat");

  // An invalid result carries the sentinel; a valid one stays within half a turn.
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (coords_invalid ? (distance_m == SENTINEL) : (distance_m <= MAX_DIST)))
    else $error("distance out of range");

  // A zero station latitude marks the result invalid.
  a_zero_lat: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && station_lat == '0) |-> ##LAT (done && coords_invalid))
    else $error("zero latitude not flagged");

endmodule

bind haversine_distance haver_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .station_lat(station_lat),
  .done(done),
  .distance_m(distance_m),
  .coords_invalid(coords_invalid)
);
`default_nettype wire
